### design/csem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore table package
// Shared types, constants and helper functions for the semaphore table.
// ----------------------------------------------------------------------------
package csem_pkg;

  localparam int NSEM  = 64;
  localparam int NPROC = 16;
  localparam int IDX_W = $clog2(NSEM);

  localparam logic signed [15:0] CNT_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_RESET   = 3'd2,
    CMD_SIGNAL  = 3'd3,
    CMD_SIGNALN = 3'd4,
    CMD_TRYWAIT = 3'd5,
    CMD_WAIT    = 3'd6,
    CMD_QUERY   = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD        = 3'd1,
    ST_OVF        = 3'd2,
    ST_WOULD      = 3'd3,
    ST_BLOCKED    = 3'd4,
    ST_BY_SIGNAL  = 3'd5,
    ST_BY_DELETE  = 3'd6,
    ST_BY_RESET   = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_WAKE,
    S_FINAL
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [7:0]         sem_id;
    logic signed [15:0] value;
    logic [3:0]         proc_id;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [7:0]         result_id;
    logic signed [15:0] count_value;
    logic [3:0]         woken_proc;
    logic               last;
  } out_t;

  // Request after front-end classification
  typedef struct packed {
    in_t  req;
    logic id_in_range;
    logic val_neg;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } free_t;

  // Highest-numbered free entry
  function automatic free_t find_free(input logic [NSEM-1:0] used);
    free_t r;
    r = '0;
    for (int i = 0; i < NSEM; i++) begin
      if (!used[i]) begin
        r.found = 1'b1;
        r.idx   = IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

### design/csem_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Semaphore table front end
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module csem_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  csem_pkg::in_t    in_data_i,
  output logic             item_valid_o,
  input  logic             item_pop_i,
  output csem_pkg::item_t  item_o
);

  csem_pkg::item_t mem_q [2];
  logic            wr_q, wr_d, rd_q, rd_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;
  csem_pkg::item_t cls;

  // Classify the incoming request
  always_comb begin
    cls.req         = in_data_i;
    cls.id_in_range = ({1'b0, in_data_i.sem_id} < 9'(csem_pkg::NSEM));
    cls.val_neg     = in_data_i.value[15];
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_q];
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = item_pop_i && item_valid_o;

  // Queue pointers
  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

endmodule

### design/csem_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Semaphore table result buffer
// Two-entry queue that decouples the engine from a stalling receiver.
// ----------------------------------------------------------------------------
module csem_outbuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  csem_pkg::out_t push_data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output csem_pkg::out_t out_data_o
);

  csem_pkg::out_t mem_q [2];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_q];
  assign push        = push_i && !full_o;
  assign pop         = out_valid_o && !out_stall_i;

  // Queue pointers
  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### design/csem_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Semaphore table engine
// Executes one request at a time against the count and wait-queue memories.
// ----------------------------------------------------------------------------
module csem_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_pop_o,
  input  csem_pkg::item_t item_i,
  input  logic            out_full_i,
  output logic            out_push_o,
  output csem_pkg::out_t  out_data_o
);

  localparam int IW = csem_pkg::IDX_W;

  csem_pkg::state_e state_q, state_d;
  csem_pkg::item_t  item_q, item_d;

  logic [csem_pkg::NSEM-1:0]  used_q, used_d;
  logic [csem_pkg::NSEM-1:0]  nonempty_q, nonempty_d;
  logic [csem_pkg::NPROC-1:0] waiting_q, waiting_d;
  logic [3:0]                 next_q [csem_pkg::NPROC];

  // Per-semaphore memories
  logic signed [15:0] cnt_mem  [csem_pkg::NSEM];
  logic [3:0]         head_mem [csem_pkg::NSEM];
  logic [3:0]         tail_mem [csem_pkg::NSEM];
  logic signed [15:0] rd_cnt_q;
  logic [3:0]         rd_head_q, rd_tail_q;

  // Wake walk state
  logic [3:0]         head_q, head_d, tail_q, tail_d;
  logic [15:0]        rem_q, rem_d;
  logic               all_q, all_d;
  csem_pkg::status_e  wst_q, wst_d;
  logic signed [15:0] wcnt_q, wcnt_d;
  csem_pkg::out_t     fin_q, fin_d;

  // Memory write ports
  logic               cnt_we, head_we, tail_we;
  logic [IW-1:0]      cnt_wa;
  logic signed [15:0] cnt_wd;
  logic [3:0]         head_wd, tail_wd;
  logic               next_we;
  logic [3:0]         next_wa, next_wd;

  logic [IW-1:0]      idx;
  logic               id_ok;
  csem_pkg::free_t    fr;
  logic signed [15:0] c, v, n, cm1;
  logic [16:0]        sum;
  logic [3:0]         p, wp, nh;
  logic               go_wake, last_pop;

  assign idx   = item_q.req.sem_id[IW-1:0];
  assign id_ok = item_q.id_in_range && used_q[idx];
  assign fr    = csem_pkg::find_free(used_q);
  assign c     = rd_cnt_q;
  assign v     = item_q.req.value;
  assign p     = item_q.req.proc_id;
  assign n     = (item_q.req.cmd == csem_pkg::CMD_SIGNAL) ? 16'sd1 : v;
  assign sum   = {c[15], c} + {n[15], n};
  assign cm1   = c - 16'sd1;
  assign wp    = head_q;
  assign nh    = next_q[wp];
  assign last_pop = (wp == tail_q) || (!all_q && (rem_q == 16'd1));

  // Decision for the addressed semaphore
  always_comb begin
    fin_d   = fin_q;
    go_wake = 1'b0;
    wst_d   = wst_q;
    wcnt_d  = wcnt_q;
    rem_d   = rem_q;
    all_d   = all_q;
    head_d  = head_q;
    tail_d  = tail_q;
    used_d  = used_q;
    nonempty_d = nonempty_q;
    waiting_d  = waiting_q;
    cnt_we  = 1'b0;
    cnt_wa  = idx;
    cnt_wd  = cm1;
    head_we = 1'b0;
    head_wd = p;
    tail_we = 1'b0;
    tail_wd = p;
    next_we = 1'b0;
    next_wa = rd_tail_q;
    next_wd = p;
    if (state_q == csem_pkg::S_EXEC) begin
      fin_d.status      = csem_pkg::ST_OK;
      fin_d.result_id   = item_q.req.sem_id;
      fin_d.count_value = c;
      fin_d.woken_proc  = 4'd0;
      fin_d.last        = 1'b1;
      head_d = rd_head_q;
      tail_d = rd_tail_q;
      rem_d  = n;
      all_d  = 1'b1;
      wcnt_d = v;
      if (item_q.req.cmd == csem_pkg::CMD_CREATE) begin
        if (item_q.val_neg || !fr.found) begin
          fin_d.status      = csem_pkg::ST_BAD;
          fin_d.result_id   = 8'd0;
          fin_d.count_value = 16'sd0;
        end else begin
          fin_d.result_id   = 8'(fr.idx);
          fin_d.count_value = v;
          cnt_we = 1'b1;
          cnt_wa = fr.idx;
          cnt_wd = v;
          used_d[fr.idx] = 1'b1;
        end
      end else if (!id_ok) begin
        fin_d.status      = csem_pkg::ST_BAD;
        fin_d.count_value = 16'sd0;
      end else begin
        case (item_q.req.cmd)
          csem_pkg::CMD_DELETE: begin
            fin_d.count_value = 16'sd0;
            used_d[idx] = 1'b0;
            go_wake = nonempty_q[idx];
            wst_d   = csem_pkg::ST_BY_DELETE;
            wcnt_d  = 16'sd0;
          end
          csem_pkg::CMD_RESET: begin
            if (item_q.val_neg) begin
              fin_d.status = csem_pkg::ST_BAD;
            end else begin
              fin_d.count_value = v;
              cnt_we  = 1'b1;
              cnt_wd  = v;
              go_wake = nonempty_q[idx];
              wst_d   = csem_pkg::ST_BY_RESET;
            end
          end
          csem_pkg::CMD_SIGNAL, csem_pkg::CMD_SIGNALN: begin
            if (n[15] || (n == 16'sd0)) begin
              fin_d.status = csem_pkg::ST_OK;
            end else if (!sum[16] && sum[15]) begin
              fin_d.status = csem_pkg::ST_OVF;
            end else begin
              fin_d.count_value = sum[15:0];
              cnt_we  = 1'b1;
              cnt_wd  = sum[15:0];
              go_wake = nonempty_q[idx];
              wst_d   = csem_pkg::ST_BY_SIGNAL;
              wcnt_d  = sum[15:0];
              all_d   = 1'b0;
            end
          end
          csem_pkg::CMD_TRYWAIT: begin
            if (c == csem_pkg::CNT_MIN) begin
              fin_d.status = csem_pkg::ST_OVF;
            end else if (c <= 16'sd0) begin
              fin_d.status = csem_pkg::ST_WOULD;
            end else begin
              fin_d.count_value = cm1;
              cnt_we = 1'b1;
            end
          end
          csem_pkg::CMD_WAIT: begin
            if (c == csem_pkg::CNT_MIN) begin
              fin_d.status = csem_pkg::ST_OVF;
            end else if (c > 16'sd0) begin
              fin_d.count_value = cm1;
              cnt_we = 1'b1;
            end else if (waiting_q[p]) begin
              fin_d.status = csem_pkg::ST_BAD;
            end else begin
              // Append the caller to the wait queue
              fin_d.status      = csem_pkg::ST_BLOCKED;
              fin_d.count_value = cm1;
              cnt_we  = 1'b1;
              tail_we = 1'b1;
              if (nonempty_q[idx]) begin
                next_we = 1'b1;
              end else begin
                head_we = 1'b1;
              end
              nonempty_d[idx] = 1'b1;
              waiting_d[p]    = 1'b1;
            end
          end
          default: begin
            fin_d.status = csem_pkg::ST_OK;
          end
        endcase
      end
    end else if ((state_q == csem_pkg::S_WAKE) && !out_full_i) begin
      // Pop one waiter per cycle while the result queue has room
      waiting_d[wp] = 1'b0;
      head_d  = nh;
      rem_d   = rem_q - 16'd1;
      head_we = 1'b1;
      head_wd = nh;
      if (wp == tail_q) begin
        nonempty_d[idx] = 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      csem_pkg::S_IDLE:  if (item_valid_i) state_d = csem_pkg::S_READ;
      csem_pkg::S_READ:  state_d = csem_pkg::S_EXEC;
      csem_pkg::S_EXEC:  state_d = go_wake ? csem_pkg::S_WAKE : csem_pkg::S_FINAL;
      csem_pkg::S_WAKE:  if (!out_full_i && last_pop) state_d = csem_pkg::S_FINAL;
      csem_pkg::S_FINAL: if (!out_full_i) state_d = csem_pkg::S_IDLE;
      default:           state_d = csem_pkg::S_IDLE;
    endcase
  end

  // Handshake and result outputs
  always_comb begin
    item_pop_o = (state_q == csem_pkg::S_IDLE) && item_valid_i;
    item_d     = item_pop_o ? item_i : item_q;
    out_push_o = 1'b0;
    out_data_o = fin_q;
    case (state_q)
      csem_pkg::S_WAKE: begin
        out_push_o             = !out_full_i;
        out_data_o.status      = wst_q;
        out_data_o.result_id   = item_q.req.sem_id;
        out_data_o.count_value = wcnt_q;
        out_data_o.woken_proc  = wp;
        out_data_o.last        = 1'b0;
      end
      csem_pkg::S_FINAL: begin
        out_push_o = !out_full_i;
      end
      default: begin
        out_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= csem_pkg::S_IDLE;
      used_q     <= '0;
      nonempty_q <= '0;
      waiting_q  <= '0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      nonempty_q <= nonempty_d;
      waiting_q  <= waiting_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    fin_q  <= fin_d;
    wst_q  <= wst_d;
    wcnt_q <= wcnt_d;
    rem_q  <= rem_d;
    all_q  <= all_d;
    head_q <= head_d;
    tail_q <= tail_d;
    if (next_we) begin
      next_q[next_wa] <= next_wd;
    end
  end

  // Memories with registered read
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (head_we) begin
      head_mem[idx] <= head_wd;
    end
    if (tail_we) begin
      tail_mem[idx] <= tail_wd;
    end
    rd_cnt_q  <= cnt_mem[idx];
    rd_head_q <= head_mem[idx];
    rd_tail_q <= tail_mem[idx];
  end

endmodule

### design/counting_semaphore_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore table
// Table of counting semaphores with per-semaphore FIFO wait queues.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_stall_o with in_data_i; a transfer
//   happens when valid is high and stall is low. Results leave on
//   out_valid_o/out_stall_i with out_data_o in the same way.
//   Each request gives one result per process it wakes (last = 0) and then
//   one final result (last = 1).
//   In the engine a request passes through queue pop, memory read and
//   execute, then gives one wake result per woken process, popping one
//   waiter per cycle while the result queue has room, and then the final
//   result. The engine takes no new request until the final result is
//   pushed.
//   A two-entry input queue takes requests while the engine is busy, and
//   a two-entry result queue lets the engine run while the receiver stalls;
//   when it fills, the engine waits.
//   Reset frees every semaphore and empties all wait queues at once.
// ----------------------------------------------------------------------------
module counting_semaphore_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  csem_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output csem_pkg::out_t out_data_o
);

  logic            item_valid, item_pop, out_full, out_push;
  csem_pkg::item_t item;
  csem_pkg::out_t  out_data;

  csem_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  csem_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .item_i       (item),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .out_data_o   (out_data)
  );

  csem_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (out_push),
    .push_data_i (out_data),
    .full_o      (out_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### design/csem_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Semaphore table port checker
// Checks result framing and the output handshake at the top-level ports.
// ----------------------------------------------------------------------------
module csem_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input csem_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input csem_pkg::out_t out_data_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Wake results are never final
  a_wake_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == csem_pkg::ST_BY_SIGNAL ||
    out_data_o.status == csem_pkg::ST_BY_DELETE ||
    out_data_o.status == csem_pkg::ST_BY_RESET) |-> !out_data_o.last)
    else $error("wake result marked last");

  // Non-final results are wakes
  a_mid_is_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |->
    (out_data_o.status == csem_pkg::ST_BY_SIGNAL ||
    out_data_o.status == csem_pkg::ST_BY_DELETE ||
    out_data_o.status == csem_pkg::ST_BY_RESET))
    else $error("non-final result is not a wake");

  // Final result carries no woken process
  a_final_proc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.woken_proc == 4'd0)
    else $error("final result has woken process");

  // Blocked caller leaves a negative count
  a_blocked_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == csem_pkg::ST_BLOCKED |->
    out_data_o.count_value[15])
    else $error("blocked with non-negative count");

endmodule

bind counting_semaphore_table csem_checker u_csem_checker (.*);
